>>> hw/rtl/fifo_queue_with_search_top_assert.svh
// Assertion macros shared by the queue checker.
`ifndef FIFO_QUEUE_WITH_SEARCH_TOP_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FQS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue check failed");

// Next-cycle implication, disabled during reset.
`define FQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue check failed");

// Next-cycle implication that is also checked across reset.
`define FQS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

>>> hw/rtl/fqs_pkg.sv
// Shared types and constants of the searchable queue.
`default_nettype none

package fqs_pkg;

  localparam int unsigned DEPTH_DEFAULT = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W = 6;

  typedef enum logic [1:0] {
    CMD_ENQUEUE,
    CMD_DEQUEUE,
    CMD_SEARCH,
    CMD_DISPLAY
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ADDED,
    ST_DEQUEUED,
    ST_FOUND,
    ST_NOT_FOUND,
    ST_EMPTY,
    ST_FULL,
    ST_SHOWN
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DEQ,
    BK_SCAN,
    BK_FINISH
  } back_state_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [VALUE_W-1:0] value;
  } cmd_req_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
    logic                      last;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/fqs_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module fqs_ram #(
  parameter int unsigned WIDTH = fqs_pkg::VALUE_W,
  parameter int unsigned DEPTH = fqs_pkg::DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fqs_front.sv
// Front end: two-entry command queue that accepts requests.
`default_nettype none

module fqs_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  input  wire fqs_pkg::cmd_t                     cmd,
  input  wire logic signed [fqs_pkg::VALUE_W-1:0] value,
  output logic                                   full,
  output logic                                   req_valid,
  output fqs_pkg::cmd_req_t                      req,
  input  wire logic                              req_pop
);

  fqs_pkg::cmd_req_t slot [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == 2'd2);
  assign req_valid = (count != 2'd0);
  assign req       = slot[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = req_pop && req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= '{cmd: cmd, value: value};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fqs_outq.sv
// Two-entry result queue that holds results until they are popped.
`default_nettype none

module fqs_outq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             res_push,
  input  wire fqs_pkg::result_t res_in,
  output logic                  res_full,
  output logic                  empty,
  output fqs_pkg::result_t      res_out,
  input  wire logic             pop
);

  fqs_pkg::result_t slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign res_out  = slot[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= res_in;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fqs_back.sv
// Back end: queue pointers, entry RAM control and the search/display walk.
`default_nettype none

module fqs_back #(
  parameter int unsigned DEPTH = fqs_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  input  wire fqs_pkg::cmd_req_t                 req,
  output logic                                   req_pop,
  output logic                                   res_push,
  output fqs_pkg::result_t                       res,
  input  wire logic                              res_full,
  output logic                                   ram_we,
  output logic [$clog2(DEPTH)-1:0]               ram_waddr,
  output logic [fqs_pkg::VALUE_W-1:0]            ram_wdata,
  output logic                                   ram_re,
  output logic [$clog2(DEPTH)-1:0]               ram_raddr,
  input  wire logic [fqs_pkg::VALUE_W-1:0]       ram_rdata
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = fqs_pkg::POS_W;

  fqs_pkg::back_state_t state, state_next;

  logic [IW-1:0]                     head, head_next;
  logic [IW-1:0]                     tail, tail_next;
  logic [CW-1:0]                     occ, occ_next;
  logic [IW-1:0]                     walk, walk_next;
  logic [CW-1:0]                     issued, issued_next;
  logic signed [fqs_pkg::VALUE_W-1:0] key, key_next;
  logic                              disp, disp_next;
  logic                              rd_valid, rd_valid_next;
  logic [PW-1:0]                     rd_pos, rd_pos_next;
  logic                              rd_final, rd_final_next;
  logic                              pend_valid, pend_valid_next;
  logic signed [fqs_pkg::VALUE_W-1:0] pend_value, pend_value_next;
  logic [PW-1:0]                     pend_pos, pend_pos_next;

  logic [CW-1:0]    issued_inc;
  logic [CW+PW-1:0] pos_wide;
  logic             match;
  logic             s2_fire;
  logic             advance;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
    return (idx == IW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign issued_inc = issued + 1'b1;
  assign pos_wide   = (CW + PW)'(issued) + 1'b1;
  assign match      = disp || (ram_rdata == key);
  assign ram_waddr  = tail;
  assign ram_wdata  = req.value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fqs_pkg::BK_IDLE;
      head       <= '0;
      tail       <= '0;
      occ        <= '0;
      walk       <= '0;
      issued     <= '0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      occ        <= occ_next;
      walk       <= walk_next;
      issued     <= issued_next;
      rd_valid   <= rd_valid_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key        <= key_next;
    disp       <= disp_next;
    rd_pos     <= rd_pos_next;
    rd_final   <= rd_final_next;
    pend_value <= pend_value_next;
    pend_pos   <= pend_pos_next;
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    occ_next        = occ;
    walk_next       = walk;
    issued_next     = issued;
    key_next        = key;
    disp_next       = disp;
    rd_valid_next   = rd_valid;
    rd_pos_next     = rd_pos;
    rd_final_next   = rd_final;
    pend_valid_next = pend_valid;
    pend_value_next = pend_value;
    pend_pos_next   = pend_pos;
    req_pop         = 1'b0;
    res_push        = 1'b0;
    res.status      = fqs_pkg::ST_EMPTY;
    res.value       = '0;
    res.pos         = '0;
    res.last        = 1'b1;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = walk;
    s2_fire         = 1'b1;
    advance         = 1'b0;

    unique case (state)
      fqs_pkg::BK_IDLE: begin
        if (req_valid) begin
          unique case (req.cmd)
            fqs_pkg::CMD_ENQUEUE: begin
              if (!res_full) begin
                req_pop  = 1'b1;
                res_push = 1'b1;
                if (occ == CW'(DEPTH)) begin
                  res.status = fqs_pkg::ST_FULL;
                end else begin
                  res.status = fqs_pkg::ST_ADDED;
                  ram_we     = 1'b1;
                  tail_next  = wrap_inc(tail);
                  occ_next   = occ + 1'b1;
                end
              end
            end
            fqs_pkg::CMD_DEQUEUE: begin
              if (occ == '0) begin
                if (!res_full) begin
                  req_pop  = 1'b1;
                  res_push = 1'b1;
                end
              end else begin
                req_pop    = 1'b1;
                ram_re     = 1'b1;
                ram_raddr  = head;
                state_next = fqs_pkg::BK_DEQ;
              end
            end
            fqs_pkg::CMD_SEARCH, fqs_pkg::CMD_DISPLAY: begin
              if (occ == '0) begin
                if (!res_full) begin
                  req_pop  = 1'b1;
                  res_push = 1'b1;
                end
              end else begin
                req_pop         = 1'b1;
                key_next        = req.value;
                disp_next       = (req.cmd == fqs_pkg::CMD_DISPLAY);
                walk_next       = head;
                issued_next     = '0;
                rd_valid_next   = 1'b0;
                pend_valid_next = 1'b0;
                state_next      = fqs_pkg::BK_SCAN;
              end
            end
          endcase
        end
      end

      fqs_pkg::BK_DEQ: begin
        if (!res_full) begin
          res_push   = 1'b1;
          res.status = fqs_pkg::ST_DEQUEUED;
          res.value  = ram_rdata;
          head_next  = wrap_inc(head);
          occ_next   = occ - 1'b1;
          state_next = fqs_pkg::BK_IDLE;
        end
      end

      fqs_pkg::BK_SCAN: begin
        // The previous match is held back so the final one can carry last.
        if (rd_valid) begin
          if (match && pend_valid) begin
            s2_fire    = !res_full;
            res_push   = !res_full;
            res.status = disp ? fqs_pkg::ST_SHOWN : fqs_pkg::ST_FOUND;
            res.value  = pend_value;
            res.pos    = pend_pos;
            res.last   = 1'b0;
          end
          if (s2_fire) begin
            if (match) begin
              pend_valid_next = 1'b1;
              pend_value_next = ram_rdata;
              pend_pos_next   = rd_pos;
            end
            if (rd_final) begin
              state_next = fqs_pkg::BK_FINISH;
            end
          end
        end
        advance = !rd_valid || s2_fire;
        if (advance) begin
          if (issued != occ) begin
            ram_re        = 1'b1;
            walk_next     = wrap_inc(walk);
            issued_next   = issued_inc;
            rd_valid_next = 1'b1;
            rd_pos_next   = pos_wide[PW-1:0];
            rd_final_next = (issued_inc == occ);
          end else begin
            rd_valid_next = 1'b0;
          end
        end
      end

      fqs_pkg::BK_FINISH: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (pend_valid) begin
            res.status = disp ? fqs_pkg::ST_SHOWN : fqs_pkg::ST_FOUND;
            res.value  = pend_value;
            res.pos    = pend_pos;
          end else begin
            res.status = fqs_pkg::ST_NOT_FOUND;
          end
          pend_valid_next = 1'b0;
          rd_valid_next   = 1'b0;
          state_next      = fqs_pkg::BK_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/fifo_queue_with_search_top.sv
// Top level of the searchable FIFO queue of signed 32-bit words.
`default_nettype none

// A queue of DEPTH signed words driven by one command per request: enqueue,
// dequeue, search for a key, or display every entry. Commands enter a
// two-entry command queue and results leave through a two-entry result
// queue, so each side may stall on its own. In the back end an enqueue is
// done in the idle state, and a dequeue goes on to the BK_DEQ state, because
// it waits for the registered read of the entry RAM. Search and display walk
// the stored entries in the BK_SCAN state and end in BK_FINISH; the walk reads
// one stored entry per cycle, unless a full result queue holds it, through the
// single read port of the entry RAM, so a full queue of DEPTH entries sets the
// longest request. A dequeue, search or display on an empty queue is answered
// in the idle state. A full result queue stretches any of these. Search and
// display give one result per match or entry, or a single not-found or empty
// result, and the final result of every command has last set.
module fifo_queue_with_search_top #(
  parameter int unsigned DEPTH = fqs_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [1:0]                        cmd,
  input  wire logic signed [fqs_pkg::VALUE_W-1:0] value,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [2:0]                             status,
  output logic signed [fqs_pkg::VALUE_W-1:0]     result_value,
  output logic [fqs_pkg::POS_W-1:0]              position,
  output logic                                   last
);

  localparam int unsigned IW = $clog2(DEPTH);

  logic                            req_valid;
  logic                            req_pop;
  fqs_pkg::cmd_req_t               req;
  logic                            res_push;
  logic                            res_full;
  fqs_pkg::result_t                res_in;
  fqs_pkg::result_t                res_out;
  logic                            ram_we;
  logic [IW-1:0]                   ram_waddr;
  logic [fqs_pkg::VALUE_W-1:0]     ram_wdata;
  logic                            ram_re;
  logic [IW-1:0]                   ram_raddr;
  logic [fqs_pkg::VALUE_W-1:0]     ram_rdata;

  fqs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .cmd       (fqs_pkg::cmd_t'(cmd)),
    .value     (value),
    .full      (full),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  fqs_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  fqs_ram #(
    .WIDTH (fqs_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fqs_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res_in),
    .res_full (res_full),
    .empty    (empty),
    .res_out  (res_out),
    .pop      (pop)
  );

  assign status       = res_out.status;
  assign result_value = res_out.value;
  assign position     = res_out.pos;
  assign last         = res_out.last;

endmodule

`default_nettype wire

>>> hw/rtl/fqs_checker.sv
// Port-level checker of the searchable queue and its bind.
`default_nettype none

`include "fifo_queue_with_search_top_assert.svh"

module fqs_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              full,
  input wire logic                              empty,
  input wire logic                              pop,
  input wire logic [2:0]                        status,
  input wire logic signed [fqs_pkg::VALUE_W-1:0] result_value,
  input wire logic [fqs_pkg::POS_W-1:0]         position,
  input wire logic                              last
);

  logic single_status;
  logic no_data_status;
  logic no_pos_status;

  assign single_status = (status == fqs_pkg::ST_ADDED) || (status == fqs_pkg::ST_DEQUEUED) ||
                         (status == fqs_pkg::ST_NOT_FOUND) || (status == fqs_pkg::ST_EMPTY) ||
                         (status == fqs_pkg::ST_FULL);
  assign no_data_status = (status == fqs_pkg::ST_ADDED) || (status == fqs_pkg::ST_NOT_FOUND) ||
                          (status == fqs_pkg::ST_EMPTY) || (status == fqs_pkg::ST_FULL);
  assign no_pos_status  = single_status;

  `FQS_ASSERT_NEXT_ALWAYS(a_reset_clear, clk, rst, empty && !full)
  `FQS_ASSERT_NEXT(a_stall_hold, clk, rst, !empty && !pop, !empty && $stable(result_value))
  `FQS_ASSERT_IMPL(a_single_last, clk, rst, !empty && single_status, last)
  `FQS_ASSERT_IMPL(a_no_data_zero, clk, rst, !empty && no_data_status, result_value == '0)
  `FQS_ASSERT_IMPL(a_no_pos_zero, clk, rst, !empty && no_pos_status, position == '0)

endmodule

bind fifo_queue_with_search_top fqs_checker u_fqs_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .status       (status),
  .result_value (result_value),
  .position     (position),
  .last         (last)
);

`default_nettype wire
